[src/pidfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pidfd_pkg;

  localparam int DataW = 32;   // Q16.16 word
  localparam int PoleW = 18;   // filter pole, Q2.16 in [-2, 2)
  localparam int IdxW  = 3;    // config register index
  localparam int FracW = 16;   // fraction bits
  localparam int WideW = 66;   // widest exact intermediate (33x32 product plus carries)

  // config register map
  localparam logic [IdxW-1:0] RegKp      = 3'd0;
  localparam logic [IdxW-1:0] RegKiStep  = 3'd1;
  localparam logic [IdxW-1:0] RegKdStep  = 3'd2;
  localparam logic [IdxW-1:0] RegPole    = 3'd3;
  localparam logic [IdxW-1:0] RegDrvMin  = 3'd4;
  localparam logic [IdxW-1:0] RegDrvMax  = 3'd5;
  localparam logic [IdxW-1:0] RegIntMin  = 3'd6;
  localparam logic [IdxW-1:0] RegIntMax  = 3'd7;

  typedef logic signed [DataW-1:0] q_t;
  typedef logic signed [PoleW-1:0] pole_t;

  localparam q_t QMax = 32'sh7FFF_FFFF;
  localparam q_t QMin = 32'sh8000_0000;

  typedef struct packed {
    q_t    kp;
    q_t    ki_step;
    q_t    kd_step;
    pole_t pole;
    q_t    drive_min;
    q_t    drive_max;
    q_t    integ_min;
    q_t    integ_max;
  } cfg_t;

  // error stage -> term stage
  typedef struct packed {
    q_t err;
    q_t meas;
  } front_t;

  // term stage -> output stage
  typedef struct packed {
    q_t prop;
    q_t integ;
    q_t deriv;
  } terms_t;

  // saturate to the 32-bit range
  function automatic q_t sat32(input logic signed [WideW-1:0] x);
    q_t r;
    if (x > WideW'(QMax)) begin
      r = QMax;
    end else if (x < WideW'(QMin)) begin
      r = QMin;
    end else begin
      r = x[DataW-1:0];
    end
    return r;
  endfunction

  // clamp to [lo, hi]; the upper test wins when the limits are inverted
  function automatic q_t clamp(input logic signed [WideW-1:0] x, input q_t lo, input q_t hi);
    q_t r;
    if (x > WideW'(hi)) begin
      r = hi;
    end else if (x < WideW'(lo)) begin
      r = lo;
    end else begin
      r = x[DataW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/pid_controller_filtered_derivative.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                                         | Handshake
// ---------+-----------------------------------------------+-------------------
// input    | in_target_value, in_measured_value (Q16.16)   | in_valid/in_ready
// result   | out_drive (Q16.16)                            | out_valid/out_ready
// config   | cfg_index, cfg_wdata                          | cfg_we, no wait
//
// Three register stages: a request passes the error, term and output registers
// in order to out_valid. Throughput is one request per cycle while out_ready
// holds, set by the integrator and derivative filter loops (one register each).
// Each stage has its own valid bit and takes a new request whenever it is
// empty or its contents move on, so bubbles collapse under a stalled output.
// Synchronous active-low reset empties the pipe, zeroes the controller state
// and loads the default gains and limits.

module pid_controller_filtered_derivative (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [31:0]          in_target_value,
  input  wire logic signed [31:0]          in_measured_value,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [31:0]               out_drive,
  // config write port
  input  wire logic                        cfg_we,
  input  wire logic [pidfd_pkg::IdxW-1:0]  cfg_index,
  input  wire logic [pidfd_pkg::DataW-1:0] cfg_wdata
);

  pidfd_pkg::cfg_t   cfg;
  pidfd_pkg::front_t front_data;
  pidfd_pkg::terms_t terms_data;
  logic              front_vld, terms_rdy;
  logic              terms_vld, mix_rdy;

  // gains, filter pole and limits
  pidfd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // stage 1: saturated error
  pidfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .i_vld    (in_valid),
    .i_rdy    (in_ready),
    .i_target (in_target_value),
    .i_meas   (in_measured_value),
    .o_vld    (front_vld),
    .o_rdy    (terms_rdy),
    .o_data   (front_data)
  );

  // stage 2: P, I, D terms; holds integrator, filter and history state
  pidfd_terms u_terms (
    .clk    (clk),
    .rst_n  (rst_n),
    .i_vld  (front_vld),
    .i_rdy  (terms_rdy),
    .i_data (front_data),
    .cfg    (cfg),
    .o_vld  (terms_vld),
    .o_rdy  (mix_rdy),
    .o_data (terms_data)
  );

  // stage 3: sum, saturate, clamp into the output register
  pidfd_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_vld   (terms_vld),
    .i_rdy   (mix_rdy),
    .i_data  (terms_data),
    .cfg     (cfg),
    .o_vld   (out_valid),
    .o_rdy   (out_ready),
    .o_drive (out_drive)
  );

endmodule

`default_nettype wire

[src/pidfd_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module pidfd_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [pidfd_pkg::IdxW-1:0]    cfg_index,
  input  wire logic [pidfd_pkg::DataW-1:0]   cfg_wdata,
  output pidfd_pkg::cfg_t                    cfg
);

  pidfd_pkg::cfg_t cfg_r;
  pidfd_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pidfd_pkg::RegKp:     cfg_nxt.kp        = cfg_wdata;
        pidfd_pkg::RegKiStep: cfg_nxt.ki_step   = cfg_wdata;
        pidfd_pkg::RegKdStep: cfg_nxt.kd_step   = cfg_wdata;
        pidfd_pkg::RegPole:   cfg_nxt.pole      = cfg_wdata[pidfd_pkg::PoleW-1:0];
        pidfd_pkg::RegDrvMin: cfg_nxt.drive_min = cfg_wdata;
        pidfd_pkg::RegDrvMax: cfg_nxt.drive_max = cfg_wdata;
        pidfd_pkg::RegIntMin: cfg_nxt.integ_min = cfg_wdata;
        pidfd_pkg::RegIntMax: cfg_nxt.integ_max = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp        <= '0;
      cfg_r.ki_step   <= '0;
      cfg_r.kd_step   <= '0;
      cfg_r.pole      <= '0;
      cfg_r.drive_min <= pidfd_pkg::QMin;
      cfg_r.drive_max <= pidfd_pkg::QMax;
      cfg_r.integ_min <= pidfd_pkg::QMin;
      cfg_r.integ_max <= pidfd_pkg::QMax;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[src/pidfd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

// Error stage: saturated target - measurement, registered with the measurement.
module pidfd_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              i_vld,
  output logic                   i_rdy,
  input  wire pidfd_pkg::q_t     i_target,
  input  wire pidfd_pkg::q_t     i_meas,
  output logic                   o_vld,
  input  wire logic              o_rdy,
  output pidfd_pkg::front_t      o_data
);

  logic                         vld_r;
  pidfd_pkg::front_t            data_r;
  pidfd_pkg::front_t            data_nxt;
  logic signed [pidfd_pkg::DataW:0] diff;

  assign i_rdy = !vld_r || o_rdy;

  always_comb begin
    diff          = (pidfd_pkg::DataW + 1)'(i_target) - (pidfd_pkg::DataW + 1)'(i_meas);
    data_nxt.err  = pidfd_pkg::sat32(pidfd_pkg::WideW'(diff));
    data_nxt.meas = i_meas;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (i_rdy) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (i_vld && i_rdy) begin
      data_r <= data_nxt;
    end
  end

  assign o_vld  = vld_r;
  assign o_data = data_r;

endmodule

`default_nettype wire

[src/pidfd_terms.sv]
`timescale 1ns / 1ps
`default_nettype none

// Term stage: proportional, trapezoidal integrator and filtered derivative.
// The controller state advances when a request moves in here.
module pidfd_terms (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              i_vld,
  output logic                   i_rdy,
  input  wire pidfd_pkg::front_t i_data,
  input  wire pidfd_pkg::cfg_t   cfg,
  output logic                   o_vld,
  input  wire logic              o_rdy,
  output pidfd_pkg::terms_t      o_data
);

  logic          vld_r;
  pidfd_pkg::q_t prop_r, prop_nxt;
  pidfd_pkg::q_t integ_acc_r, integ_acc_nxt;
  pidfd_pkg::q_t deriv_acc_r, deriv_acc_nxt;
  pidfd_pkg::q_t last_err_r;
  pidfd_pkg::q_t last_meas_r;
  logic          load;

  logic signed [2*pidfd_pkg::DataW-1:0]             prop_prod;
  logic signed [pidfd_pkg::DataW:0]                 err_sum;
  logic signed [2*pidfd_pkg::DataW:0]               integ_prod;
  logic signed [pidfd_pkg::WideW-1:0]               integ_sum;
  logic signed [pidfd_pkg::DataW:0]                 meas_diff;
  logic signed [2*pidfd_pkg::DataW:0]               kd_prod;
  logic signed [pidfd_pkg::PoleW+pidfd_pkg::DataW-1:0] pole_prod;
  logic signed [pidfd_pkg::WideW-1:0]               deriv_sum;

  assign i_rdy = !vld_r || o_rdy;
  assign load  = i_vld && i_rdy;

  always_comb begin
    prop_prod = i_data.err * cfg.kp;
    prop_nxt  = pidfd_pkg::sat32(pidfd_pkg::WideW'(prop_prod >>> pidfd_pkg::FracW));

    // Ki*T/2 * (e + e_prev), floored, then anti-windup clamp
    err_sum       = (pidfd_pkg::DataW + 1)'(i_data.err) + (pidfd_pkg::DataW + 1)'(last_err_r);
    integ_prod    = err_sum * cfg.ki_step;
    integ_sum     = pidfd_pkg::WideW'(integ_prod >>> pidfd_pkg::FracW)
                  + pidfd_pkg::WideW'(integ_acc_r);
    integ_acc_nxt = pidfd_pkg::clamp(integ_sum, cfg.integ_min, cfg.integ_max);

    // d = pole*d_prev + kd*(m_prev - m), one floor over the exact sum
    meas_diff     = (pidfd_pkg::DataW + 1)'(last_meas_r) - (pidfd_pkg::DataW + 1)'(i_data.meas);
    kd_prod       = meas_diff * cfg.kd_step;
    pole_prod     = cfg.pole * deriv_acc_r;
    deriv_sum     = pidfd_pkg::WideW'(kd_prod) + pidfd_pkg::WideW'(pole_prod);
    deriv_acc_nxt = pidfd_pkg::sat32(deriv_sum >>> pidfd_pkg::FracW);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      integ_acc_r <= '0;
      deriv_acc_r <= '0;
      last_err_r  <= '0;
      last_meas_r <= '0;
    end else begin
      if (i_rdy) begin
        vld_r <= i_vld;
      end
      if (load) begin
        integ_acc_r <= integ_acc_nxt;
        deriv_acc_r <= deriv_acc_nxt;
        last_err_r  <= i_data.err;
        last_meas_r <= i_data.meas;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prop_r <= prop_nxt;
    end
  end

  assign o_vld        = vld_r;
  assign o_data.prop  = prop_r;
  assign o_data.integ = integ_acc_r;
  assign o_data.deriv = deriv_acc_r;

endmodule

`default_nettype wire

[src/pidfd_mix.sv]
`timescale 1ns / 1ps
`default_nettype none

// Output stage: sum of terms, 32-bit saturation, drive clamp.
module pidfd_mix (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              i_vld,
  output logic                   i_rdy,
  input  wire pidfd_pkg::terms_t i_data,
  input  wire pidfd_pkg::cfg_t   cfg,
  output logic                   o_vld,
  input  wire logic              o_rdy,
  output pidfd_pkg::q_t          o_drive
);

  logic                               vld_r;
  pidfd_pkg::q_t                      drive_r, drive_nxt;
  logic signed [pidfd_pkg::WideW-1:0] sum;

  assign i_rdy = !vld_r || o_rdy;

  always_comb begin
    sum       = pidfd_pkg::WideW'(i_data.prop) + pidfd_pkg::WideW'(i_data.integ)
              + pidfd_pkg::WideW'(i_data.deriv);
    drive_nxt = pidfd_pkg::clamp(pidfd_pkg::WideW'(pidfd_pkg::sat32(sum)),
                                 cfg.drive_min, cfg.drive_max);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (i_rdy) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (i_vld && i_rdy) begin
      drive_r <= drive_nxt;
    end
  end

  assign o_vld   = vld_r;
  assign o_drive = drive_r;

endmodule

`default_nettype wire

[src/pidfd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module pidfd_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic signed [31:0]          out_drive
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive))
    else $error("out_drive changed while stalled");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // with the output free every stage can move, so input is never held off
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  // draining with out_ready high and no new request leaves the pipe empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready && !(in_valid && in_ready)) ##1
    (out_ready && !(in_valid && in_ready)) ##1
    (out_ready && !(in_valid && in_ready)) |=> !out_valid)
    else $error("result appeared without a request");

endmodule

bind pid_controller_filtered_derivative pidfd_checker u_pidfd_checker (.*);

`default_nettype wire
